>>> design/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Shared constants and helpers for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int MAX_KEYS    = 16;
  localparam int CHANS       = 14;
  localparam int STORE_DEPTH = MAX_KEYS * CHANS;
  localparam int FRAC_BITS   = 16;

  // input beat actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // channel code of the key time and of the relative time result
  localparam logic [3:0]  CH_TIME   = 4'd0;

  localparam logic [3:0]  LAST_CHAN = 4'(CHANS - 1);
  localparam logic [3:0]  LAST_KEY  = 4'(MAX_KEYS - 1);
  localparam logic [32:0] EPSILON   = 33'd13;
  localparam logic [16:0] FRAC_ONE  = 17'd65536;

  // store address of one channel of one key
  function automatic logic [7:0] store_addr(logic [3:0] key, logic [3:0] ch);
    return ({4'b0, key} * 8'(CHANS)) + {4'b0, ch};
  endfunction

  // clamp a wide signed value into 32 bits
  function automatic logic [31:0] sat32(logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) begin
      return 32'h7FFFFFFF;
    end else if (v < 36'shF80000000) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

>>> design/kli_store.sv
// ----------------------------------------------------------------------------
// kli_store
// Keyframe word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kli_store
  import kli_pkg::*;
(
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [7:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [STORE_DEPTH];
  logic [31:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/kli_div.sv
// ----------------------------------------------------------------------------
// kli_div
// Restoring divider giving floor(dividend * 2^16 / divisor), one bit a cycle.
// Dividend is below divisor, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module kli_div
  import kli_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [15:0] quot
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [15:0] q_r;
  logic [32:0] rem_dbl;
  logic        take;

  // trial subtract of the doubled remainder
  assign rem_dbl = {rem_r, 1'b0};
  assign take    = rem_dbl >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= 32'(take ? (rem_dbl - {1'b0, dvs_r}) : rem_dbl);
      q_r   <= {q_r[14:0], take};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> design/keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Keyframe table with a forward interval search and per-channel lerp.
//
//   channel  direction  handshake          payload
//   in_      input      valid / ready      action, key index, channel, value, time
//   out_     output     valid / ready      channel, value, last of frame
//   cfg_     input      write enable only  keyframe count
//
// A write beat is taken in the idle state. An evaluate beat runs a search
// (k intervals tested, one memory read each; none when the pointer has no
// interval ahead), loads the two key times, forms the fraction, through the
// serial divider when it runs, gives the relative time result, then reads,
// multiplies and gives each channel result while out is ready, reading the
// store through its single read port.
// One beat is worked on at a time; in_ready is high only when idle.
// Reset clears the count, search pointer and control; the store is not cleared.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator
  import kli_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_key_index,
  input  logic [3:0]  in_channel_select,
  input  logic [31:0] in_channel_value,
  input  logic [31:0] in_sample_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel,
  output logic [31:0] out_value,
  output logic        out_last_of_frame,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SCAN_A = 13'b0000000000010,
    S_SCAN_B = 13'b0000000000100,
    S_LD_A   = 13'b0000000001000,
    S_LD_B   = 13'b0000000010000,
    S_FRAC   = 13'b0000000100000,
    S_DIV    = 13'b0000001000000,
    S_REL    = 13'b0000010000000,
    S_WAIT   = 13'b0000100000000,
    S_CH_A   = 13'b0001000000000,
    S_CH_B   = 13'b0010000000000,
    S_MUL    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]         count_r;
  logic [3:0]         ptr_r;
  logic [4:0]         idx_r;
  logic signed [31:0] t_r;
  logic signed [31:0] ta_r;
  logic signed [31:0] ts_r;
  logic signed [32:0] rel_r;
  logic signed [32:0] span_r;
  logic [16:0]        f_r;
  logic signed [31:0] a_r;
  logic signed [50:0] prod_r;
  logic [3:0]         ch_r;
  logic               out_valid_r;
  logic [3:0]         out_channel_r;
  logic [31:0]        out_value_r;
  logic               out_last_r;

  logic               in_fire, out_fire;
  logic               wr_ok;
  logic [7:0]         rd_addr;
  logic [31:0]        rd_data;
  logic signed [31:0] rd_s;
  logic signed [32:0] t_eps;
  logic               hit;
  logic               more;
  logic [3:0]         dst;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_q;
  logic signed [35:0] lerp;

  assign in_ready = state_r == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign wr_ok = in_fire && (in_action == ACT_WRITE)
                 && ({1'b0, in_key_index} < count_r)
                 && (in_channel_select <= LAST_CHAN);

  assign rd_s  = $signed(rd_data);
  assign t_eps = $signed({t_r[31], t_r}) + $signed(EPSILON);
  assign hit   = (t_eps >= 33'(ta_r)) && (t_eps < 33'(rd_s));
  assign more  = (idx_r + 5'd2) < count_r;
  assign dst   = (ptr_r == LAST_KEY) ? ptr_r : ptr_r + 4'd1;

  assign div_start = (state_r == S_FRAC) && (span_r > 33'sd0) && (rel_r > 33'sd0)
                     && (rel_r < span_r);

  assign lerp = 36'(a_r) + 36'(prod_r >>> FRAC_BITS);

  // store read address per state
  always_comb begin
    unique case (state_r)
      S_SCAN_A: rd_addr = store_addr(4'(idx_r + 5'd1), CH_TIME);
      S_SCAN_B: begin
        if (hit) begin
          rd_addr = store_addr(idx_r[3:0], CH_TIME);
        end else if (more) begin
          rd_addr = store_addr(4'(idx_r + 5'd2), CH_TIME);
        end else begin
          rd_addr = store_addr(ptr_r, CH_TIME);
        end
      end
      S_LD_A:  rd_addr = store_addr(dst, CH_TIME);
      S_CH_A:  rd_addr = store_addr(ptr_r, ch_r);
      S_CH_B:  rd_addr = store_addr(dst, ch_r);
      default: rd_addr = store_addr(ptr_r, CH_TIME);
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_action == ACT_EVAL)) begin
          state_nxt = (5'({1'b0, ptr_r} + 5'd1) < count_r) ? S_SCAN_A : S_LD_A;
        end
      end
      S_SCAN_A: state_nxt = S_SCAN_B;
      S_SCAN_B: begin
        if (hit || !more) begin
          state_nxt = S_LD_A;
        end
      end
      S_LD_A:  state_nxt = S_LD_B;
      S_LD_B:  state_nxt = S_FRAC;
      S_FRAC:  state_nxt = div_start ? S_DIV : S_REL;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_REL;
        end
      end
      S_REL:   state_nxt = S_WAIT;
      S_WAIT: begin
        if (out_ready) begin
          state_nxt = (ch_r == LAST_CHAN) ? S_IDLE : S_CH_A;
        end
      end
      S_CH_A:  state_nxt = S_CH_B;
      S_CH_B:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_WAIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        count_r <= (cfg_wr_data > 5'(MAX_KEYS)) ? 5'(MAX_KEYS) : cfg_wr_data;
      end
      if (in_fire && (in_action == ACT_WRITE)) begin
        ptr_r <= '0;
      end else if (state_r == S_SCAN_B && hit) begin
        ptr_r <= idx_r[3:0];
      end
      if (state_r == S_REL || state_r == S_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        t_r   <= $signed(in_sample_time);
        idx_r <= {1'b0, ptr_r};
        ch_r  <= '0;
      end
      S_SCAN_A: ta_r <= rd_s;
      S_SCAN_B: begin
        ta_r  <= rd_s;
        idx_r <= idx_r + 5'd1;
      end
      S_LD_A: ts_r <= rd_s;
      S_LD_B: begin
        rel_r  <= 33'(t_r) - 33'(ts_r);
        span_r <= 33'(rd_s) - 33'(ts_r);
      end
      S_FRAC: begin
        if (span_r <= 33'sd0) begin
          f_r <= FRAC_ONE;
        end else if (rel_r <= 33'sd0) begin
          f_r <= '0;
        end else if (rel_r >= span_r) begin
          f_r <= FRAC_ONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          f_r <= {1'b0, div_q};
        end
      end
      S_REL: begin
        out_channel_r <= CH_TIME;
        out_value_r   <= sat32(36'(rel_r));
        out_last_r    <= 1'b0;
      end
      S_WAIT: begin
        if (out_ready && ch_r != LAST_CHAN) begin
          ch_r <= ch_r + 4'd1;
        end
      end
      S_CH_A: ;
      S_CH_B: a_r <= rd_s;
      S_MUL:  prod_r <= (33'(rd_s) - 33'(a_r)) * $signed({1'b0, f_r});
      S_OUT: begin
        out_channel_r <= ch_r;
        out_value_r   <= sat32(lerp);
        out_last_r    <= ch_r == LAST_CHAN;
      end
      default: ;
    endcase
  end

  kli_store u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (store_addr(in_key_index, in_channel_select)),
    .wdata (in_channel_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rel_r[31:0]),
    .divisor  (span_r[31:0]),
    .done     (div_done),
    .quot     (div_q)
  );

  assign out_valid         = out_valid_r;
  assign out_channel       = out_channel_r;
  assign out_value         = out_value_r;
  assign out_last_of_frame = out_last_r;

  // checks
  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_WAIT) else $error("result shown outside wait");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r)) else $error("input taken while result pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_of_frame) |=> state_r == S_IDLE)
    else $error("frame end did not return to idle");

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_action == ACT_EVAL)) |=> (state_r == S_SCAN_A || state_r == S_LD_A))
    else $error("evaluate beat did not start");

endmodule
